@@ hw/rtl/six_digit_seven_segment_scanner_defines.svh @@
// ----------------------------------------------------------------------------
// six digit seven segment scanner: assertion macros
// shared helpers for the concurrent checks on the scanner ports
// ----------------------------------------------------------------------------
`ifndef SIX_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define SIX_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

// condition implies consequence on the same edge
`define SDSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scanner check failed");

// condition implies consequence on the next edge
`define SDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scanner check failed");

`endif

@@ hw/rtl/sdss_pkg.sv @@
// ----------------------------------------------------------------------------
// sdss_pkg
// shared constants, types and tables of the six digit display scanner
// ----------------------------------------------------------------------------
package sdss_pkg;

	localparam int DIGIT_COUNT   = 6;
	localparam int POS_W         = 3;
	localparam int VALUE_W       = 24;
	localparam int READING_SHIFT = 5;
	localparam int REM_W         = VALUE_W - READING_SHIFT;
	localparam int SEG_W         = 7;
	localparam int DIGIT_W       = 4;
	localparam int PLACE_W       = 17;
	localparam int CMP_W         = REM_W + 1;
	localparam int MAX_DIGIT     = 9;

	localparam logic [POS_W-1:0] POS_FIRST = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(DIGIT_COUNT - 1);

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic [REM_W-1:0]   rem;
	} digit_res_t;

	// decimal weight of each scan position, most significant first
	function automatic logic [PLACE_W-1:0] place_value(input logic [POS_W-1:0] pos);
		logic [PLACE_W-1:0] p;
		unique case (pos)
			3'd0:    p = PLACE_W'(100000);
			3'd1:    p = PLACE_W'(10000);
			3'd2:    p = PLACE_W'(1000);
			3'd3:    p = PLACE_W'(100);
			3'd4:    p = PLACE_W'(10);
			default: p = PLACE_W'(1);
		endcase
		return p;
	endfunction

	// segments a..g in bits 0..6, high lights
	function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		unique case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

@@ hw/rtl/six_digit_seven_segment_scanner.sv @@
// ----------------------------------------------------------------------------
// six_digit_seven_segment_scanner
// one input word per refresh tick, one segment/enable word out per tick
// ----------------------------------------------------------------------------
// Each accepted input word is one refresh tick and yields exactly one output
// word in the following cycle. The block takes a word in every cycle while
// the output side keeps up: the output register is reloaded on the same edge
// it is emptied. Throughput, with no output stall, is one tick per cycle, set
// by the combinational digit compare ladder that closes the loop through the
// remainder register. At digit 0 the reading shifted right by 5 is latched;
// digits then follow hundred-thousands first, with one active-low digit enable per tick.
module six_digit_seven_segment_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // display_value[23:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // segment_pattern[6:0], digit_enables[12:7],
	                                   // digit_position[15:13]
);
	import sdss_pkg::*;

	logic [POS_W-1:0]       scan_pos_q;
	logic [REM_W-1:0]       rem_q;
	logic [POS_W-1:0]       pos;
	logic [REM_W-1:0]       rem_sel;
	digit_res_t             res;
	logic                   in_accept;
	logic                   out_valid_q;
	logic [SEG_W-1:0]       seg_q;
	logic [DIGIT_COUNT-1:0] enables_q;
	logic [POS_W-1:0]       pos_out_q;

	// unreachable positions fall back to the first digit
	assign pos     = (scan_pos_q > POS_LAST) ? POS_FIRST : scan_pos_q;
	assign rem_sel = (pos == POS_FIRST) ? s_axis_tdata[VALUE_W-1:READING_SHIFT] : rem_q;

	sdss_digit u_digit (
		.pos    (pos),
		.rem_in (rem_sel),
		.res    (res)
	);

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_pos_q  <= POS_FIRST;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_accept) begin
				scan_pos_q  <= (pos == POS_LAST) ? POS_FIRST : pos + POS_W'(1);
				rem_q       <= res.rem;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word, no reset needed
	always_ff @(posedge clk) begin
		if (in_accept) begin
			seg_q     <= seg_pattern(res.digit);
			enables_q <= ~(DIGIT_COUNT'(1) << pos);
			pos_out_q <= pos;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {pos_out_q, enables_q, seg_q};

endmodule

@@ hw/rtl/sdss_digit.sv @@
// ----------------------------------------------------------------------------
// sdss_digit
// peels one decimal digit off the remainder with a nine step compare ladder
// ----------------------------------------------------------------------------
module sdss_digit (
	input  logic [sdss_pkg::POS_W-1:0] pos,
	input  logic [sdss_pkg::REM_W-1:0] rem_in,
	output sdss_pkg::digit_res_t       res
);
	import sdss_pkg::*;

	logic [PLACE_W-1:0] place;
	logic [CMP_W-1:0]   rem_ext;
	logic [MAX_DIGIT:1] ge;
	logic [DIGIT_W-1:0] q;
	logic [CMP_W-1:0]   taken;

	assign place   = place_value(pos);
	assign rem_ext = CMP_W'(rem_in);

	// each rung compares against k times the place value
	always_comb begin
		for (int k = 1; k <= MAX_DIGIT; k++) begin
			ge[k] = rem_ext >= (CMP_W'(k) * CMP_W'(place));
		end
	end

	// rungs are monotonic, so the count of passed rungs is the digit
	always_comb begin
		q = '0;
		for (int k = 1; k <= MAX_DIGIT; k++) begin
			q = q + DIGIT_W'(ge[k]);
		end
	end

	assign taken     = CMP_W'(q) * CMP_W'(place);
	assign res.digit = q;
	assign res.rem   = REM_W'(rem_ext - taken);

endmodule

@@ hw/rtl/sdss_checker.sv @@
// ----------------------------------------------------------------------------
// sdss_checker
// port level checks on the six digit display scanner, bound to the top
// ----------------------------------------------------------------------------
`include "six_digit_seven_segment_scanner_defines.svh"

module sdss_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);
	import sdss_pkg::*;

	logic out_stall;
	logic in_word;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign in_word   = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);

	// a stalled word holds
	`SDSS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

	// the low enable matches the reported position
	`SDSS_ASSERT_IMPLY(a_enable_pos, clk, arst_n, m_axis_tvalid,
		(~m_axis_tdata[12:7]) == (6'd1 << m_axis_tdata[15:13]))

	// only real digit positions are shown
	`SDSS_ASSERT_IMPLY(a_pos_range, clk, arst_n, m_axis_tvalid,
		m_axis_tdata[15:13] <= POS_LAST)

	// every accepted word shows up at the output on the next edge
	`SDSS_ASSERT_NEXT(a_in_to_out, clk, arst_n, in_word, m_axis_tvalid)

endmodule

bind six_digit_seven_segment_scanner sdss_checker u_sdss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ test/six_digit_seven_segment_scanner_tb.sv @@
// ----------------------------------------------------------------------------
// six_digit_seven_segment_scanner_tb
// drives refresh ticks into the scanner and checks every segment/enable word
// against a digit-by-digit prediction of the scan, with random gaps on the
// input and random back-pressure on the output
// ----------------------------------------------------------------------------
module six_digit_seven_segment_scanner_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import sdss_pkg::*;

	localparam int CYCLE_LIMIT = 200000;

	// output word as it sits on m_axis_tdata, lowest field last
	typedef struct packed {
		logic [POS_W-1:0]       position;
		logic [DIGIT_COUNT-1:0] enables;
		logic [SEG_W-1:0]       segments;
	} scan_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [VALUE_W-1:0] s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [15:0]        m_axis_tdata;

	six_digit_seven_segment_scanner dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // display_value[23:0]
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)    // segment_pattern[6:0], digit_enables[12:7],
		                                 // digit_position[15:13]
	);

	always #1 clk = ~clk;

	// predicted scan state
	logic [POS_W-1:0] model_pos = '0;
	logic [REM_W-1:0] model_rem = '0;

	scan_word_t pending_words[$];

	int  mismatch_count = 0;
	int  tick_count = 0;
	int  latched_count = 0;
	int  checked_count = 0;
	int  cycle_count = 0;
	bit  gaps_enabled = 1'b0;
	int  burst_left = 0;

	// receiver stall pattern
	int  rx_mode = 0;
	int  rx_mode_left = 0;
	int  rx_stall_left = 0;
	scan_word_t got_word;
	scan_word_t want_word;

	function automatic int decimal_weight(input logic [POS_W-1:0] pos);
		case (pos)
			3'd0:    return 100000;
			3'd1:    return 10000;
			3'd2:    return 1000;
			3'd3:    return 100;
			3'd4:    return 10;
			default: return 1;
		endcase
	endfunction

	function automatic logic [SEG_W-1:0] glyph(input int digit);
		case (digit)
			0:       return 7'b0111111;
			1:       return 7'b0000110;
			2:       return 7'b1011011;
			3:       return 7'b1001111;
			4:       return 7'b1100110;
			5:       return 7'b1101101;
			6:       return 7'b1111101;
			7:       return 7'b0000111;
			8:       return 7'b1111111;
			default: return 7'b1101111;
		endcase
	endfunction

	// one tick of the scan: digit out, remainder and position advanced
	task automatic predict_tick(input logic [VALUE_W-1:0] reading, output scan_word_t w);
		logic [POS_W-1:0] pos;
		int               rest;
		int               weight;
		int               digit;
		pos = model_pos;
		if (pos >= DIGIT_COUNT)
			pos = POS_FIRST;
		rest = (pos == POS_FIRST) ? int'(reading >> READING_SHIFT) : int'(model_rem);
		if (pos == POS_FIRST)
			latched_count++;
		weight = decimal_weight(pos);
		digit = 0;
		// comparator ladder, saturating at nine
		while (digit < MAX_DIGIT && rest >= weight) begin
			rest -= weight;
			digit++;
		end
		model_rem = REM_W'(rest);
		model_pos = (pos == POS_LAST) ? POS_FIRST : pos + 1'b1;
		w.position = pos;
		w.enables  = ~(DIGIT_COUNT'(1) << pos);
		w.segments = glyph(digit);
	endtask

	task automatic send_tick(input logic [VALUE_W-1:0] value);
		scan_word_t w;
		int         gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		do @(posedge clk); while (!s_axis_tready);
		predict_tick(value, w);
		pending_words.push_back(w);
		tick_count++;
		if (gaps_enabled) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(1, 6);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic stop_sending();
		s_axis_tvalid <= 1'b0;
	endtask

	// reading for a digit 0 tick: boundaries, small values and full range
	function automatic logic [VALUE_W-1:0] pick_reading();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0:       return '0;
					1:       return '1;
					2:       return 24'd3200000;   // exactly 100000 after the shift
					3:       return 24'd3199999;   // 99999 after the shift
					4:       return 24'hFFFFE0;
					default: return 24'h00001F;
				endcase
			end
			1, 2:    return VALUE_W'($urandom_range(0, 3200));
			3:       return VALUE_W'($urandom_range(0, 320000));
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// value for a tick at any position; ignored ones get junk
	function automatic logic [VALUE_W-1:0] pick_value();
		if (model_pos == POS_FIRST)
			return pick_reading();
		return VALUE_W'($urandom);
	endfunction

	task automatic test_directed_readings();
		logic [VALUE_W-1:0] reading;
		gaps_enabled = 1'b0;
		// zero, the largest reading, and two that show every digit between them
		for (int r = 0; r < 4; r++) begin
			case (r)
				0:       reading = '0;
				1:       reading = '1;
				2:       reading = VALUE_W'(123456 << READING_SHIFT);
				default: reading = VALUE_W'((467890 << READING_SHIFT) + 31);
			endcase
			send_tick(reading);
			// the other positions must not pick up the input
			for (int i = 1; i < DIGIT_COUNT; i++)
				send_tick(i[0] ? '1 : '0);
		end
	endtask

	task automatic test_random_readings(input int count);
		gaps_enabled = 1'b1;
		for (int i = 0; i < count; i++)
			send_tick(pick_value());
	endtask

	task automatic test_steady_stream(input int count);
		gaps_enabled = 1'b0;
		for (int i = 0; i < count; i++)
			send_tick(pick_value());
	endtask

	task automatic test_pause_for_drain();
		gaps_enabled = 1'b1;
		for (int i = 0; i < 20; i++)
			send_tick(pick_value());
		stop_sending();
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat ($urandom_range(1, 8)) @(posedge clk);
		for (int i = 0; i < 20; i++)
			send_tick(pick_value());
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("word %0d: %s expected 0x%0h, got 0x%0h", checked_count, name,
					want, got);
		end
	endtask

	// output side: check accepted words, then pick next tready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_word = scan_word_t'(m_axis_tdata);
			if (pending_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word 0x%04h", m_axis_tdata);
			end else begin
				want_word = pending_words.pop_front();
				check_field("segment_pattern", int'(want_word.segments),
					int'(got_word.segments));
				check_field("digit_enables", int'(want_word.enables),
					int'(got_word.enables));
				check_field("digit_position", int'(want_word.position),
					int'(got_word.position));
			end
			checked_count++;
		end

		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(32, 200);
		end else begin
			rx_mode_left--;
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: begin
				// occasional long stalls
				if (rx_stall_left > 0) begin
					m_axis_tready <= 1'b0;
					rx_stall_left--;
				end else begin
					m_axis_tready <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						rx_stall_left = $urandom_range(3, 12);
				end
			end
		endcase
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
			pending_words.size());
		$display("six_digit_seven_segment_scanner: mismatch");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_readings();
		test_random_readings(300);
		test_pause_for_drain();
		test_steady_stream(150);
		test_random_readings(260);

		stop_sending();
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d ticks sent, %0d readings latched, %0d words checked",
			tick_count, latched_count, checked_count);
		$display("%0d mismatches", mismatch_count);
		if (mismatch_count == 0 && pending_words.size() == 0) begin
			$display("six_digit_seven_segment_scanner: match");
		end else begin
			$display("six_digit_seven_segment_scanner: mismatch");
		end
		$finish;
	end

endmodule
